>>> src/tsqc_pkg.sv
// Package for the touch sample qualifier and calibrator.
// Holds field widths, fixed thresholds, codes and the structs passed between modules.
// No dependencies.
package tsqc_pkg;

    localparam int RAW_W   = 12;
    localparam int COORD_W = 10;
    localparam int SUM_W   = 14;
    localparam int SIZE_W  = 11;
    localparam int CNT_W   = 2;
    localparam int ROT_W   = 2;
    localparam int KIND_W  = 2;
    localparam int NUM_W   = 23;
    localparam int DEN_W   = 12;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;
    localparam int IDX_W   = 3;

    localparam logic [RAW_W-1:0] Y_CEILING = 12'd4000;
    localparam logic [RAW_W-1:0] XZ_FLOOR  = 12'd50;
    localparam int               CAL_EDGE  = 15;

    localparam int               RECIP_SHIFT = 17;
    localparam logic [16:0]      RECIP3      = 17'd43691;

    localparam logic [KIND_W-1:0] EVT_PRESSED  = 2'd0;
    localparam logic [KIND_W-1:0] EVT_HELD     = 2'd1;
    localparam logic [KIND_W-1:0] EVT_RELEASED = 2'd2;

    localparam logic [ROT_W-1:0] ROT_LANDSCAPE     = 2'd0;
    localparam logic [ROT_W-1:0] ROT_PORTRAIT      = 2'd1;
    localparam logic [ROT_W-1:0] ROT_LANDSCAPE_INV = 2'd2;
    localparam logic [ROT_W-1:0] ROT_PORTRAIT_INV  = 2'd3;

    localparam logic [IDX_W-1:0] REG_PRESSURE_LIMIT = 3'd0;
    localparam logic [IDX_W-1:0] REG_CAL_X_LOW      = 3'd1;
    localparam logic [IDX_W-1:0] REG_CAL_X_HIGH     = 3'd2;
    localparam logic [IDX_W-1:0] REG_CAL_Y_LOW      = 3'd3;
    localparam logic [IDX_W-1:0] REG_CAL_Y_HIGH     = 3'd4;
    localparam logic [IDX_W-1:0] REG_SENSOR_WIDTH   = 3'd5;
    localparam logic [IDX_W-1:0] REG_SENSOR_HEIGHT  = 3'd6;
    localparam logic [IDX_W-1:0] REG_ROTATION       = 3'd7;

    typedef struct packed {
        logic [SUM_W-1:0] sum_x;
        logic [SUM_W-1:0] sum_y;
        logic [SUM_W-1:0] sum_z;
        logic [CNT_W-1:0] valid_count;
        logic             good;
    } job_t;

    typedef struct packed {
        logic [RAW_W-1:0]  cal_x_low;
        logic [RAW_W-1:0]  cal_x_high;
        logic [RAW_W-1:0]  cal_y_low;
        logic [RAW_W-1:0]  cal_y_high;
        logic [SIZE_W-1:0] sensor_width;
        logic [SIZE_W-1:0] sensor_height;
        logic [ROT_W-1:0]  rotation;
    } cal_t;

    typedef struct packed {
        logic [COORD_W-1:0] touch_x;
        logic [COORD_W-1:0] touch_y;
        logic [RAW_W-1:0]   pressure;
        logic [KIND_W-1:0]  event_kind;
    } result_t;

endpackage

>>> src/tsqc_fifo.sv
// Small register-based first-in first-out queue of generic width and depth.
// Used between the front and back parts and in front of the result ports.
// No dependencies.
module tsqc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

>>> src/tsqc_front.sv
// Front part: qualifies each ADC sample and accumulates valid ones over a burst.
// At the end of a burst it pushes one job into the job queue.
// Depends on tsqc_pkg.
module tsqc_front #(
    parameter int SAMPLES_PER_REPORT = 3
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [tsqc_pkg::RAW_W-1:0]  raw_x,
    input  logic [tsqc_pkg::RAW_W-1:0]  raw_y,
    input  logic [tsqc_pkg::RAW_W-1:0]  raw_z1,
    input  logic [tsqc_pkg::RAW_W-1:0]  pressure_limit,
    output tsqc_pkg::job_t              job,
    output logic                        job_push,
    input  logic                        job_full
);

    import tsqc_pkg::*;

    localparam logic [CNT_W-1:0] BURST_LEN = CNT_W'(SAMPLES_PER_REPORT);
    localparam logic [CNT_W-1:0] HALF_LEN  = CNT_W'(SAMPLES_PER_REPORT / 2);

    logic [CNT_W-1:0] burst_count_reg;
    logic [CNT_W-1:0] valid_count_reg;
    logic [SUM_W-1:0] sum_x_reg;
    logic [SUM_W-1:0] sum_y_reg;
    logic [SUM_W-1:0] sum_z_reg;

    logic             accept;
    logic             sample_ok;
    logic             burst_end;
    logic [CNT_W-1:0] burst_count_next;
    logic [CNT_W-1:0] valid_count_next;
    logic [SUM_W-1:0] sum_x_next;
    logic [SUM_W-1:0] sum_y_next;
    logic [SUM_W-1:0] sum_z_next;

    assign full   = job_full;
    assign accept = push && !job_full;

    assign sample_ok = (raw_y < Y_CEILING) && (raw_x > XZ_FLOOR) &&
                       (raw_z1 >= XZ_FLOOR) && (raw_z1 < pressure_limit);

    always_comb
    begin
        burst_count_next = burst_count_reg + 1'b1;
        valid_count_next = valid_count_reg;
        sum_x_next       = sum_x_reg;
        sum_y_next       = sum_y_reg;
        sum_z_next       = sum_z_reg;
        if (sample_ok)
        begin
            valid_count_next = valid_count_reg + 1'b1;
            sum_x_next       = sum_x_reg + SUM_W'(raw_x);
            sum_y_next       = sum_y_reg + SUM_W'(raw_y);
            sum_z_next       = sum_z_reg + SUM_W'(raw_z1);
        end
    end

    assign burst_end = (burst_count_next == BURST_LEN);

    assign job_push          = accept && burst_end;
    assign job.sum_x         = sum_x_next;
    assign job.sum_y         = sum_y_next;
    assign job.sum_z         = sum_z_next;
    assign job.valid_count   = valid_count_next;
    assign job.good          = (valid_count_next != '0) && (valid_count_next >= HALF_LEN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            burst_count_reg <= '0;
            valid_count_reg <= '0;
            sum_x_reg       <= '0;
            sum_y_reg       <= '0;
            sum_z_reg       <= '0;
        end
        else if (accept)
        begin
            if (burst_end)
            begin
                burst_count_reg <= '0;
                valid_count_reg <= '0;
                sum_x_reg       <= '0;
                sum_y_reg       <= '0;
                sum_z_reg       <= '0;
            end
            else
            begin
                burst_count_reg <= burst_count_next;
                valid_count_reg <= valid_count_next;
                sum_x_reg       <= sum_x_next;
                sum_y_reg       <= sum_y_next;
                sum_z_reg       <= sum_z_next;
            end
        end
    end

endmodule

>>> src/tsqc_div.sv
// Serial restoring divider for unsigned magnitudes, one quotient bit per cycle.
// Used by the back part for the calibration map of each axis.
// Depends on tsqc_pkg.
module tsqc_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [tsqc_pkg::NUM_W-1:0]  dividend,
    input  logic [tsqc_pkg::DEN_W-1:0]  divisor,
    output logic                        busy,
    output logic [tsqc_pkg::NUM_W-1:0]  quotient
);

    import tsqc_pkg::*;

    localparam int STEP_W = $clog2(NUM_W + 1);

    logic [DEN_W-1:0]  rem_reg;
    logic [NUM_W-1:0]  quo_reg;
    logic [DEN_W-1:0]  div_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;

    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    trial_sub;
    logic              fits;

    assign trial     = {rem_reg, quo_reg[NUM_W-1]};
    assign fits      = (trial >= {1'b0, div_reg});
    assign trial_sub = trial - {1'b0, div_reg};
    assign busy      = busy_reg;
    assign quotient  = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= STEP_W'(NUM_W);
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg - 1'b1;
            if (step_reg == STEP_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
        end
    end

endmodule

>>> src/tsqc_back.sv
// Back part: averages a burst, maps both axes through the calibration, clamps,
// rotates and tracks the touch state to produce pressed, held and released events.
// Depends on tsqc_pkg and tsqc_div.
module tsqc_back (
    input  logic                clk,
    input  logic                rst_n,
    input  tsqc_pkg::job_t      job,
    input  logic                job_empty,
    output logic                job_pop,
    input  tsqc_pkg::cal_t      cal,
    output tsqc_pkg::result_t   res,
    output logic                res_push,
    input  logic                res_full
);

    import tsqc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AVG,
        ST_PROD,
        ST_DIV,
        ST_CLAMP,
        ST_ROTATE,
        ST_EMIT
    } state_t;

    state_t               state_reg;
    job_t                 job_reg;
    logic [1:0]           avg_idx_reg;
    logic [RAW_W-1:0]     avg_x_reg;
    logic [RAW_W-1:0]     avg_y_reg;
    logic [RAW_W-1:0]     avg_z_reg;
    logic                 neg_x_reg;
    logic                 neg_y_reg;
    logic                 dzero_x_reg;
    logic                 dzero_y_reg;
    logic [SIZE_W-1:0]    nx_reg;
    logic [SIZE_W-1:0]    ny_reg;
    logic                 touching_reg;
    logic [COORD_W-1:0]   last_x_reg;
    logic [COORD_W-1:0]   last_y_reg;
    result_t              res_reg;

    logic [SUM_W-1:0]     sum_sel;
    logic [SUM_W+16:0]    prod3;
    logic [RAW_W-1:0]     avg_val;

    logic signed [RAW_W:0]    diff_x;
    logic signed [RAW_W:0]    diff_y;
    logic signed [SIZE_W:0]   span_x;
    logic signed [SIZE_W:0]   span_y;
    logic signed [24:0]       prod_x;
    logic signed [24:0]       prod_y;
    logic signed [RAW_W:0]    den_x;
    logic signed [RAW_W:0]    den_y;
    logic [NUM_W-1:0]         mag_x;
    logic [NUM_W-1:0]         mag_y;
    logic [DEN_W-1:0]         den_mag_x;
    logic [DEN_W-1:0]         den_mag_y;

    logic                     div_start;
    logic                     busy_x;
    logic                     busy_y;
    logic [NUM_W-1:0]         quo_x;
    logic [NUM_W-1:0]         quo_y;

    logic signed [12:0]       dx;
    logic signed [12:0]       dy;
    logic signed [12:0]       w_edge;
    logic signed [12:0]       h_edge;

    function automatic logic [SIZE_W-1:0] clamp_axis(
        input logic [NUM_W-1:0]  q,
        input logic              neg,
        input logic              dzero,
        input logic [SIZE_W-1:0] size
    );
        logic signed [24:0] cal_v;
        logic signed [24:0] n;
        logic signed [24:0] lim;
        cal_v = $signed({2'b00, q});
        if (dzero)
        begin
            cal_v = '0;
        end
        else if (neg)
        begin
            cal_v = -cal_v;
        end
        n   = cal_v + $signed(25'(CAL_EDGE));
        lim = $signed({14'b0, size}) - 25'sd1;
        if (n > lim)
        begin
            n = lim;
        end
        if (n < 0)
        begin
            n = '0;
        end
        return n[SIZE_W-1:0];
    endfunction

    function automatic logic [COORD_W-1:0] sat_coord(input logic signed [12:0] v);
        logic [COORD_W-1:0] r;
        if (v < 0)
        begin
            r = '0;
        end
        else if (v > $signed(13'((1 << COORD_W) - 1)))
        begin
            r = '1;
        end
        else
        begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

    assign job_pop  = (state_reg == ST_IDLE) && !job_empty;
    assign res_push = (state_reg == ST_EMIT) && !res_full;
    assign res      = res_reg;

    always_comb
    begin
        unique case (avg_idx_reg)
            2'd0:    sum_sel = job_reg.sum_x;
            2'd1:    sum_sel = job_reg.sum_y;
            default: sum_sel = job_reg.sum_z;
        endcase
    end

    assign prod3 = (SUM_W+17)'(sum_sel) * (SUM_W+17)'(RECIP3);

    always_comb
    begin
        unique case (job_reg.valid_count)
            2'd1:    avg_val = sum_sel[RAW_W-1:0];
            2'd2:    avg_val = sum_sel[RAW_W:1];
            2'd3:    avg_val = prod3[RECIP_SHIFT+RAW_W-1:RECIP_SHIFT];
            default: avg_val = '0;
        endcase
    end

    assign diff_x = $signed({1'b0, avg_x_reg}) - $signed({1'b0, cal.cal_x_low});
    assign diff_y = $signed({1'b0, avg_y_reg}) - $signed({1'b0, cal.cal_y_low});
    assign span_x = $signed({1'b0, cal.sensor_width}) - $signed((SIZE_W+1)'(2 * CAL_EDGE));
    assign span_y = $signed({1'b0, cal.sensor_height}) - $signed((SIZE_W+1)'(2 * CAL_EDGE));
    assign prod_x = diff_x * span_x;
    assign prod_y = diff_y * span_y;
    assign den_x  = $signed({1'b0, cal.cal_x_high}) - $signed({1'b0, cal.cal_x_low});
    assign den_y  = $signed({1'b0, cal.cal_y_high}) - $signed({1'b0, cal.cal_y_low});

    assign mag_x     = prod_x[24] ? NUM_W'(-prod_x) : prod_x[NUM_W-1:0];
    assign mag_y     = prod_y[24] ? NUM_W'(-prod_y) : prod_y[NUM_W-1:0];
    assign den_mag_x = den_x[RAW_W] ? DEN_W'(-den_x) : den_x[DEN_W-1:0];
    assign den_mag_y = den_y[RAW_W] ? DEN_W'(-den_y) : den_y[DEN_W-1:0];

    assign div_start = (state_reg == ST_PROD);

    tsqc_div u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mag_x),
        .divisor  (den_mag_x),
        .busy     (busy_x),
        .quotient (quo_x)
    );

    tsqc_div u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mag_y),
        .divisor  (den_mag_y),
        .busy     (busy_y),
        .quotient (quo_y)
    );

    assign w_edge = $signed({2'b00, cal.sensor_width}) - 13'sd1 - $signed({2'b00, nx_reg});
    assign h_edge = $signed({2'b00, cal.sensor_height}) - 13'sd1 - $signed({2'b00, ny_reg});

    always_comb
    begin
        unique case (cal.rotation)
            ROT_LANDSCAPE:
            begin
                dx = $signed({2'b00, ny_reg});
                dy = w_edge;
            end
            ROT_PORTRAIT:
            begin
                dx = $signed({2'b00, nx_reg});
                dy = $signed({2'b00, ny_reg});
            end
            ROT_LANDSCAPE_INV:
            begin
                dx = h_edge;
                dy = $signed({2'b00, nx_reg});
            end
            ROT_PORTRAIT_INV:
            begin
                dx = w_edge;
                dy = h_edge;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            avg_idx_reg  <= '0;
            touching_reg <= 1'b0;
            last_x_reg   <= '0;
            last_y_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (!job_empty)
                    begin
                        job_reg <= job;
                        if (job.good)
                        begin
                            avg_idx_reg <= '0;
                            state_reg   <= ST_AVG;
                        end
                        else if (touching_reg)
                        begin
                            res_reg.touch_x    <= last_x_reg;
                            res_reg.touch_y    <= last_y_reg;
                            res_reg.pressure   <= '0;
                            res_reg.event_kind <= EVT_RELEASED;
                            touching_reg       <= 1'b0;
                            state_reg          <= ST_EMIT;
                        end
                    end
                end
                ST_AVG:
                begin
                    unique case (avg_idx_reg)
                        2'd0:    avg_x_reg <= avg_val;
                        2'd1:    avg_y_reg <= avg_val;
                        default: avg_z_reg <= avg_val;
                    endcase
                    if (avg_idx_reg == 2'd2)
                    begin
                        state_reg <= ST_PROD;
                    end
                    else
                    begin
                        avg_idx_reg <= avg_idx_reg + 1'b1;
                    end
                end
                ST_PROD:
                begin
                    neg_x_reg   <= prod_x[24] ^ den_x[RAW_W];
                    neg_y_reg   <= prod_y[24] ^ den_y[RAW_W];
                    dzero_x_reg <= (den_x == '0);
                    dzero_y_reg <= (den_y == '0);
                    state_reg   <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (!busy_x && !busy_y)
                    begin
                        state_reg <= ST_CLAMP;
                    end
                end
                ST_CLAMP:
                begin
                    nx_reg    <= clamp_axis(quo_x, neg_x_reg, dzero_x_reg, cal.sensor_width);
                    ny_reg    <= clamp_axis(quo_y, neg_y_reg, dzero_y_reg, cal.sensor_height);
                    state_reg <= ST_ROTATE;
                end
                ST_ROTATE:
                begin
                    res_reg.touch_x    <= sat_coord(dx);
                    res_reg.touch_y    <= sat_coord(dy);
                    res_reg.pressure   <= avg_z_reg;
                    res_reg.event_kind <= touching_reg ? EVT_HELD : EVT_PRESSED;
                    last_x_reg         <= sat_coord(dx);
                    last_y_reg         <= sat_coord(dy);
                    touching_reg       <= 1'b1;
                    state_reg          <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (!res_full)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

>>> src/touch_sample_qualify_calibrate_top.sv
// Top level of the touch sample qualifier and calibrator.
// Holds the configuration registers and connects front, job queue, back and result queue.
// Depends on tsqc_pkg, tsqc_fifo, tsqc_front, tsqc_back and tsqc_div.
//
// Usage:
// Samples enter through push/full, one (raw_x, raw_y, raw_z1) triple per beat.
// Events leave through empty/pop; the oldest event sits on touch_x, touch_y,
// pressure and event_kind while empty is low.
// The front accepts one beat per cycle while the job queue has room. Every
// SAMPLES_PER_REPORT beats it hands one burst to the back part.
// In the back part a burst that yields a touch event passes averaging, the products,
// the 23-step serial dividers of the calibration map, clamping, rotation and emit;
// an empty burst that ends a touch goes straight to emit as a release, else yields
// nothing. The next job is taken only once the last event is in the result queue.
// When the receiver stalls, results collect in the result queue, then the back
// part holds, then the job queue fills and full rises.
// Reset empties both queues, clears the accumulators and the touch state, and loads the
// configuration registers with their default values. The user must write configuration
// over the APB port only while the block is idle; the block does not enforce it.
module touch_sample_qualify_calibrate_top #(
    parameter int SAMPLES_PER_REPORT = 3,
    parameter int JOB_DEPTH          = 2,
    parameter int RESULT_DEPTH       = 2
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [tsqc_pkg::RAW_W-1:0]    raw_x,
    input  logic [tsqc_pkg::RAW_W-1:0]    raw_y,
    input  logic [tsqc_pkg::RAW_W-1:0]    raw_z1,
    output logic                          empty,
    input  logic                          pop,
    output logic [tsqc_pkg::COORD_W-1:0]  touch_x,
    output logic [tsqc_pkg::COORD_W-1:0]  touch_y,
    output logic [tsqc_pkg::RAW_W-1:0]    pressure,
    output logic [tsqc_pkg::KIND_W-1:0]   event_kind,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tsqc_pkg::ADDR_W-1:0]   paddr,
    input  logic [tsqc_pkg::DATA_W-1:0]   pwdata,
    output logic [tsqc_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    import tsqc_pkg::*;

    logic [RAW_W-1:0]  pressure_limit_reg;
    logic [RAW_W-1:0]  cal_x_low_reg;
    logic [RAW_W-1:0]  cal_x_high_reg;
    logic [RAW_W-1:0]  cal_y_low_reg;
    logic [RAW_W-1:0]  cal_y_high_reg;
    logic [SIZE_W-1:0] sensor_width_reg;
    logic [SIZE_W-1:0] sensor_height_reg;
    logic [ROT_W-1:0]  rotation_reg;

    logic              cfg_write;
    logic [IDX_W-1:0]  cfg_idx;
    cal_t              cal;

    job_t              front_job;
    job_t              back_job;
    logic [$bits(job_t)-1:0]    back_job_bits;
    logic              job_push;
    logic              job_full;
    logic              job_empty;
    logic              job_pop;

    result_t           back_res;
    result_t           out_res;
    logic [$bits(result_t)-1:0] out_res_bits;
    logic              res_push;
    logic              res_full;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = paddr[ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pressure_limit_reg <= 12'd4095;
            cal_x_low_reg      <= 12'd0;
            cal_x_high_reg     <= 12'd4095;
            cal_y_low_reg      <= 12'd0;
            cal_y_high_reg     <= 12'd4095;
            sensor_width_reg   <= 11'd320;
            sensor_height_reg  <= 11'd480;
            rotation_reg       <= ROT_PORTRAIT;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                REG_PRESSURE_LIMIT: pressure_limit_reg <= pwdata[RAW_W-1:0];
                REG_CAL_X_LOW:      cal_x_low_reg      <= pwdata[RAW_W-1:0];
                REG_CAL_X_HIGH:     cal_x_high_reg     <= pwdata[RAW_W-1:0];
                REG_CAL_Y_LOW:      cal_y_low_reg      <= pwdata[RAW_W-1:0];
                REG_CAL_Y_HIGH:     cal_y_high_reg     <= pwdata[RAW_W-1:0];
                REG_SENSOR_WIDTH:   sensor_width_reg   <= pwdata[SIZE_W-1:0];
                REG_SENSOR_HEIGHT:  sensor_height_reg  <= pwdata[SIZE_W-1:0];
                REG_ROTATION:       rotation_reg       <= pwdata[ROT_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_PRESSURE_LIMIT: prdata = DATA_W'(pressure_limit_reg);
            REG_CAL_X_LOW:      prdata = DATA_W'(cal_x_low_reg);
            REG_CAL_X_HIGH:     prdata = DATA_W'(cal_x_high_reg);
            REG_CAL_Y_LOW:      prdata = DATA_W'(cal_y_low_reg);
            REG_CAL_Y_HIGH:     prdata = DATA_W'(cal_y_high_reg);
            REG_SENSOR_WIDTH:   prdata = DATA_W'(sensor_width_reg);
            REG_SENSOR_HEIGHT:  prdata = DATA_W'(sensor_height_reg);
            REG_ROTATION:       prdata = DATA_W'(rotation_reg);
        endcase
    end

    assign cal.cal_x_low     = cal_x_low_reg;
    assign cal.cal_x_high    = cal_x_high_reg;
    assign cal.cal_y_low     = cal_y_low_reg;
    assign cal.cal_y_high    = cal_y_high_reg;
    assign cal.sensor_width  = sensor_width_reg;
    assign cal.sensor_height = sensor_height_reg;
    assign cal.rotation      = rotation_reg;

    tsqc_front #(
        .SAMPLES_PER_REPORT (SAMPLES_PER_REPORT)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .raw_x          (raw_x),
        .raw_y          (raw_y),
        .raw_z1         (raw_z1),
        .pressure_limit (pressure_limit_reg),
        .job            (front_job),
        .job_push       (job_push),
        .job_full       (job_full)
    );

    tsqc_fifo #(
        .WIDTH ($bits(job_t)),
        .DEPTH (JOB_DEPTH)
    ) u_job_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (job_push),
        .wr_data (front_job),
        .full    (job_full),
        .pop     (job_pop),
        .rd_data (back_job_bits),
        .empty   (job_empty)
    );

    assign back_job = job_t'(back_job_bits);

    tsqc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (back_job),
        .job_empty (job_empty),
        .job_pop   (job_pop),
        .cal       (cal),
        .res       (back_res),
        .res_push  (res_push),
        .res_full  (res_full)
    );

    tsqc_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (RESULT_DEPTH)
    ) u_res_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_push),
        .wr_data (back_res),
        .full    (res_full),
        .pop     (pop),
        .rd_data (out_res_bits),
        .empty   (empty)
    );

    assign out_res    = result_t'(out_res_bits);
    assign touch_x    = out_res.touch_x;
    assign touch_y    = out_res.touch_y;
    assign pressure   = out_res.pressure;
    assign event_kind = out_res.event_kind;

    a_release_zero_pressure: assert property (
        @(posedge clk) disable iff (!rst_n)
        (!empty && event_kind == EVT_RELEASED) |-> (pressure == '0)
    ) else $error("Released event carries nonzero pressure.");

    a_kind_known: assert property (
        @(posedge clk) disable iff (!rst_n)
        !empty |-> (event_kind == EVT_PRESSED || event_kind == EVT_HELD ||
                    event_kind == EVT_RELEASED)
    ) else $error("Event kind outside the defined codes.");

    a_full_follows_jobs: assert property (
        @(posedge clk) disable iff (!rst_n)
        full |-> job_empty == 1'b0
    ) else $error("Front stalls while the job queue is empty.");

endmodule

>>> tb/sv/tb_top.sv
// Self-checking testbench for touch_sample_qualify_calibrate_top.
// A scoreboard class predicts the touch events from the accepted sample beats and
// checks them against the result queue; depends on tsqc_pkg and the RTL only.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tsqc_pkg::*;

    localparam int BURST_LEN        = 3;
    localparam int NUM_REGS         = 8;
    localparam int SETTLE_CYCLES    = 64;
    localparam int HOLD_CYCLES      = 400;
    localparam int RANDOM_PHASES    = 9;
    localparam int BURSTS_PER_PHASE = 33;
    localparam int MAX_REPORTS      = 10;

    logic                clk;
    logic                rst_n;
    logic                push;
    logic                full;
    logic [RAW_W-1:0]    raw_x;
    logic [RAW_W-1:0]    raw_y;
    logic [RAW_W-1:0]    raw_z1;
    logic                empty;
    logic                pop;
    logic [COORD_W-1:0]  touch_x;
    logic [COORD_W-1:0]  touch_y;
    logic [RAW_W-1:0]    pressure;
    logic [KIND_W-1:0]   event_kind;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    int tx_idle_pct;
    int rx_idle_pct;
    bit hold_req;
    int settings_used;

    touch_sample_qualify_calibrate_top #(
        .SAMPLES_PER_REPORT(BURST_LEN)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .raw_x      (raw_x),
        .raw_y      (raw_y),
        .raw_z1     (raw_z1),
        .empty      (empty),
        .pop        (pop),
        .touch_x    (touch_x),
        .touch_y    (touch_y),
        .pressure   (pressure),
        .event_kind (event_kind),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    class touch_scoreboard;
        logic [RAW_W-1:0]   plimit;
        logic [RAW_W-1:0]   x_lo;
        logic [RAW_W-1:0]   x_hi;
        logic [RAW_W-1:0]   y_lo;
        logic [RAW_W-1:0]   y_hi;
        logic [SIZE_W-1:0]  width;
        logic [SIZE_W-1:0]  height;
        logic [ROT_W-1:0]   rot;

        logic [CNT_W-1:0]   burst_n;
        logic [CNT_W-1:0]   valid_n;
        logic [SUM_W-1:0]   acc_x;
        logic [SUM_W-1:0]   acc_y;
        logic [SUM_W-1:0]   acc_z;
        logic               touching;
        logic [COORD_W-1:0] last_x;
        logic [COORD_W-1:0] last_y;

        result_t pending_events[$];
        int      error_count;
        int      samples;
        int      kinds_seen[4];

        function new();
            plimit   = 12'd4095;
            x_lo     = 12'd0;
            x_hi     = 12'd4095;
            y_lo     = 12'd0;
            y_hi     = 12'd4095;
            width    = 11'd320;
            height   = 11'd480;
            rot      = ROT_PORTRAIT;
            burst_n  = '0;
            valid_n  = '0;
            acc_x    = '0;
            acc_y    = '0;
            acc_z    = '0;
            touching = 1'b0;
            last_x   = '0;
            last_y   = '0;
        endfunction

        function void flag(string msg);
            error_count++;
            if (error_count <= MAX_REPORTS)
            begin
                $display("tb_top: %s", msg);
            end
        endfunction

        function void set_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] v);
            case (idx)
                REG_PRESSURE_LIMIT: plimit = v[RAW_W-1:0];
                REG_CAL_X_LOW:      x_lo   = v[RAW_W-1:0];
                REG_CAL_X_HIGH:     x_hi   = v[RAW_W-1:0];
                REG_CAL_Y_LOW:      y_lo   = v[RAW_W-1:0];
                REG_CAL_Y_HIGH:     y_hi   = v[RAW_W-1:0];
                REG_SENSOR_WIDTH:   width  = v[SIZE_W-1:0];
                REG_SENSOR_HEIGHT:  height = v[SIZE_W-1:0];
                REG_ROTATION:       rot    = v[ROT_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [DATA_W-1:0] reg_value(logic [IDX_W-1:0] idx);
            case (idx)
                REG_PRESSURE_LIMIT: return DATA_W'(plimit);
                REG_CAL_X_LOW:      return DATA_W'(x_lo);
                REG_CAL_X_HIGH:     return DATA_W'(x_hi);
                REG_CAL_Y_LOW:      return DATA_W'(y_lo);
                REG_CAL_Y_HIGH:     return DATA_W'(y_hi);
                REG_SENSOR_WIDTH:   return DATA_W'(width);
                REG_SENSOR_HEIGHT:  return DATA_W'(height);
                default:            return DATA_W'(rot);
            endcase
        endfunction

        function void check_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] got);
            if (got !== reg_value(idx))
            begin
                flag($sformatf("register %0d read back 0x%0h, expected 0x%0h",
                               idx, got, reg_value(idx)));
            end
        endfunction

        // Linear map with the fixed edge margin, division truncating toward zero.
        function int calibrate_axis(int raw, int lo, int hi, int size);
            int span;
            int den;
            int cal;
            int n;
            span = size - 2 * CAL_EDGE;
            den  = hi - lo;
            cal  = 0;
            if (den != 0)
            begin
                cal = ((raw - lo) * span) / den;
            end
            n = cal + CAL_EDGE;
            if (n > size - 1)
            begin
                n = size - 1;
            end
            if (n < 0)
            begin
                n = 0;
            end
            return n;
        endfunction

        function logic [COORD_W-1:0] clip_coord(int v);
            if (v < 0)
            begin
                return '0;
            end
            if (v > 1023)
            begin
                return 10'd1023;
            end
            return v[COORD_W-1:0];
        endfunction

        function void note_sample(logic [RAW_W-1:0] x, logic [RAW_W-1:0] y,
                                  logic [RAW_W-1:0] z);
            logic [SUM_W-1:0] avg_x;
            logic [SUM_W-1:0] avg_y;
            logic [SUM_W-1:0] avg_z;
            logic             good;
            int               nx;
            int               ny;
            int               dx;
            int               dy;
            int               w;
            int               h;
            result_t          ev;
            samples++;
            if (y < Y_CEILING && x > XZ_FLOOR && z >= XZ_FLOOR && z < plimit)
            begin
                acc_x   = acc_x + x;
                acc_y   = acc_y + y;
                acc_z   = acc_z + z;
                valid_n = valid_n + 1'b1;
            end
            burst_n = burst_n + 1'b1;
            if (burst_n < BURST_LEN)
            begin
                return;
            end
            good = (valid_n != 0) && (valid_n >= BURST_LEN / 2);
            avg_x = '0;
            avg_y = '0;
            avg_z = '0;
            if (good)
            begin
                avg_x = acc_x / valid_n;
                avg_y = acc_y / valid_n;
                avg_z = acc_z / valid_n;
            end
            burst_n = '0;
            valid_n = '0;
            acc_x   = '0;
            acc_y   = '0;
            acc_z   = '0;
            if (!good)
            begin
                if (touching)
                begin
                    touching = 1'b0;
                    ev.touch_x    = last_x;
                    ev.touch_y    = last_y;
                    ev.pressure   = '0;
                    ev.event_kind = EVT_RELEASED;
                    pending_events.push_back(ev);
                end
                return;
            end
            w  = width;
            h  = height;
            nx = calibrate_axis(avg_x, x_lo, x_hi, w);
            ny = calibrate_axis(avg_y, y_lo, y_hi, h);
            case (rot)
                ROT_LANDSCAPE:
                begin
                    dx = ny;
                    dy = w - 1 - nx;
                end
                ROT_LANDSCAPE_INV:
                begin
                    dx = h - 1 - ny;
                    dy = nx;
                end
                ROT_PORTRAIT_INV:
                begin
                    dx = w - 1 - nx;
                    dy = h - 1 - ny;
                end
                default:
                begin
                    dx = nx;
                    dy = ny;
                end
            endcase
            last_x = clip_coord(dx);
            last_y = clip_coord(dy);
            ev.touch_x    = last_x;
            ev.touch_y    = last_y;
            ev.pressure   = avg_z[RAW_W-1:0];
            ev.event_kind = touching ? EVT_HELD : EVT_PRESSED;
            touching = 1'b1;
            pending_events.push_back(ev);
        endfunction

        function void check_event(result_t got);
            result_t want;
            if (pending_events.size() == 0)
            begin
                flag($sformatf("unexpected event x=%0d y=%0d p=%0d kind=%0d",
                               got.touch_x, got.touch_y, got.pressure, got.event_kind));
                return;
            end
            want = pending_events.pop_front();
            kinds_seen[got.event_kind]++;
            if (got.touch_x !== want.touch_x || got.touch_y !== want.touch_y ||
                got.pressure !== want.pressure || got.event_kind !== want.event_kind)
            begin
                flag($sformatf("event mismatch: expected x=%0d y=%0d p=%0d kind=%0d, got x=%0d y=%0d p=%0d kind=%0d",
                               want.touch_x, want.touch_y, want.pressure, want.event_kind,
                               got.touch_x, got.touch_y, got.pressure, got.event_kind));
            end
        endfunction
    endclass

    touch_scoreboard sb;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("tb_top: timed out with beats still outstanding");
        $display("tb_top: done, errors");
        $finish;
    end

    // Result side: pop decided at the falling edge, with one long hold-off on request.
    initial
    begin
        pop = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            pop <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            sb.check_event({touch_x, touch_y, pressure, event_kind});
        end
    end

    task automatic send_sample(input logic [RAW_W-1:0] x, input logic [RAW_W-1:0] y,
                               input logic [RAW_W-1:0] z);
        @(negedge clk);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push   <= 1'b1;
        raw_x  <= x;
        raw_y  <= y;
        raw_z1 <= z;
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
        sb.note_sample(x, y, z);
    endtask

    task automatic settle();
        @(negedge clk);
        push <= 1'b0;
        while (sb.pending_events.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] v);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        sb.set_reg(idx, v);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic read_back_all();
        for (int i = 0; i < NUM_REGS; i++)
        begin
            @(negedge clk);
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            paddr   <= {i[IDX_W-1:0], 2'b00};
            @(negedge clk);
            penable <= 1'b1;
            @(posedge clk);
            while (!pready)
            begin
                @(posedge clk);
            end
            sb.check_reg(i[IDX_W-1:0], prdata);
            @(negedge clk);
            psel    <= 1'b0;
            penable <= 1'b0;
        end
    endtask

    function automatic void pick_valid(output logic [RAW_W-1:0] x,
                                       output logic [RAW_W-1:0] y,
                                       output logic [RAW_W-1:0] z);
        x = RAW_W'($urandom_range(4095, 51));
        y = RAW_W'($urandom_range(3999));
        z = (sb.plimit > XZ_FLOOR) ? RAW_W'($urandom_range(sb.plimit - 1, 50))
                                   : RAW_W'($urandom_range(4095));
        case ($urandom_range(15))
            0: x = 12'd51;
            1: x = 12'd4095;
            2: y = 12'd3999;
            3: y = 12'd0;
            4: z = 12'd50;
            5: z = (sb.plimit > XZ_FLOOR) ? sb.plimit - 1'b1 : z;
            default: ;
        endcase
    endfunction

    function automatic void pick_invalid(output logic [RAW_W-1:0] x,
                                         output logic [RAW_W-1:0] y,
                                         output logic [RAW_W-1:0] z);
        pick_valid(x, y, z);
        case ($urandom_range(3))
            0: y = RAW_W'($urandom_range(4095, 4000));
            1: x = RAW_W'($urandom_range(50));
            2: z = RAW_W'($urandom_range(49));
            default: z = RAW_W'($urandom_range(4095, sb.plimit));
        endcase
    endfunction

    task automatic send_burst();
        int               mode;
        logic [RAW_W-1:0] x;
        logic [RAW_W-1:0] y;
        logic [RAW_W-1:0] z;
        mode = $urandom_range(99);
        for (int i = 0; i < BURST_LEN; i++)
        begin
            if (mode < 55 || (mode < 75 && $urandom_range(2) != 0))
            begin
                pick_valid(x, y, z);
            end
            else if (mode < 90)
            begin
                pick_invalid(x, y, z);
            end
            else
            begin
                x = RAW_W'($urandom);
                y = RAW_W'($urandom);
                z = RAW_W'($urandom);
            end
            send_sample(x, y, z);
        end
    endtask

    task automatic apply_setting(input int ph);
        logic [DATA_W-1:0] vals [NUM_REGS];
        case (ph)
            0:
            begin
                vals[REG_PRESSURE_LIMIT] = 2048;
                vals[REG_CAL_X_LOW]      = 4095;
                vals[REG_CAL_X_HIGH]     = 0;
                vals[REG_CAL_Y_LOW]      = 200;
                vals[REG_CAL_Y_HIGH]     = 200;
                vals[REG_SENSOR_WIDTH]   = 64;
                vals[REG_SENSOR_HEIGHT]  = 1024;
                vals[REG_ROTATION]       = DATA_W'(ROT_LANDSCAPE);
            end
            1:
            begin
                vals[REG_PRESSURE_LIMIT] = 4095;
                vals[REG_CAL_X_LOW]      = 100;
                vals[REG_CAL_X_HIGH]     = 3900;
                vals[REG_CAL_Y_LOW]      = 300;
                vals[REG_CAL_Y_HIGH]     = 3800;
                vals[REG_SENSOR_WIDTH]   = 1024;
                vals[REG_SENSOR_HEIGHT]  = 64;
                vals[REG_ROTATION]       = DATA_W'(ROT_LANDSCAPE_INV);
            end
            2:
            begin
                vals[REG_PRESSURE_LIMIT] = 1000;
                vals[REG_CAL_X_LOW]      = 0;
                vals[REG_CAL_X_HIGH]     = 0;
                vals[REG_CAL_Y_LOW]      = 4095;
                vals[REG_CAL_Y_HIGH]     = 0;
                vals[REG_SENSOR_WIDTH]   = 2047;
                vals[REG_SENSOR_HEIGHT]  = 2047;
                vals[REG_ROTATION]       = DATA_W'(ROT_PORTRAIT_INV);
            end
            3:
            begin
                vals[REG_PRESSURE_LIMIT] = 3000;
                vals[REG_CAL_X_LOW]      = 2000;
                vals[REG_CAL_X_HIGH]     = 2100;
                vals[REG_CAL_Y_LOW]      = 50;
                vals[REG_CAL_Y_HIGH]     = 60;
                vals[REG_SENSOR_WIDTH]   = 0;
                vals[REG_SENSOR_HEIGHT]  = 1;
                vals[REG_ROTATION]       = DATA_W'(ROT_LANDSCAPE);
            end
            4:
            begin
                vals[REG_PRESSURE_LIMIT] = 51;
                vals[REG_CAL_X_LOW]      = 0;
                vals[REG_CAL_X_HIGH]     = 4095;
                vals[REG_CAL_Y_LOW]      = 0;
                vals[REG_CAL_Y_HIGH]     = 4095;
                vals[REG_SENSOR_WIDTH]   = 320;
                vals[REG_SENSOR_HEIGHT]  = 480;
                vals[REG_ROTATION]       = DATA_W'(ROT_PORTRAIT);
            end
            default:
            begin
                vals[REG_PRESSURE_LIMIT] = $urandom_range(4095, 60);
                if ($urandom_range(3) == 0)
                begin
                    vals[REG_CAL_X_LOW]  = $urandom_range(4095);
                    vals[REG_CAL_X_HIGH] = $urandom_range(4095);
                    vals[REG_CAL_Y_LOW]  = $urandom_range(4095);
                    vals[REG_CAL_Y_HIGH] = $urandom_range(4095);
                end
                else
                begin
                    vals[REG_CAL_X_LOW]  = $urandom_range(600);
                    vals[REG_CAL_X_HIGH] = $urandom_range(4095, 3400);
                    vals[REG_CAL_Y_LOW]  = $urandom_range(600);
                    vals[REG_CAL_Y_HIGH] = $urandom_range(4095, 3400);
                end
                if (ph == RANDOM_PHASES - 1)
                begin
                    vals[REG_SENSOR_WIDTH]  = $urandom_range(2047);
                    vals[REG_SENSOR_HEIGHT] = $urandom_range(2047);
                end
                else
                begin
                    vals[REG_SENSOR_WIDTH]  = $urandom_range(1024, 64);
                    vals[REG_SENSOR_HEIGHT] = $urandom_range(1024, 64);
                end
                vals[REG_ROTATION] = $urandom_range(3);
            end
        endcase
        for (int i = 0; i < NUM_REGS; i++)
        begin
            write_reg(i[IDX_W-1:0], vals[i]);
        end
        read_back_all();
        settings_used++;
    endtask

    initial
    begin
        rst_n       = 1'b0;
        push        = 1'b0;
        raw_x       = '0;
        raw_y       = '0;
        raw_z1      = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        tx_idle_pct = 18;
        rx_idle_pct = 60;
        sb          = new();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        read_back_all();
        settings_used = 1;

        // Directed bursts on the reset configuration.
        send_sample(12'd2048, 12'd2048, 12'd1000);
        send_sample(12'd2048, 12'd2048, 12'd1000);
        send_sample(12'd2048, 12'd2048, 12'd1000);
        send_sample(12'd4095, 12'd3999, 12'd4094);
        send_sample(12'd51, 12'd0, 12'd50);
        send_sample(12'd4095, 12'd3999, 12'd4094);
        send_sample(12'd1000, 12'd2000, 12'd300);
        send_sample(12'd1000, 12'd4000, 12'd300);
        send_sample(12'd1000, 12'd2000, 12'd4095);
        send_sample(12'd50, 12'd100, 12'd100);
        send_sample(12'd100, 12'd100, 12'd49);
        send_sample(12'd0, 12'd4095, 12'd0);
        send_sample(12'd4095, 12'd4095, 12'd4095);
        send_sample(12'd0, 12'd0, 12'd0);
        send_sample(12'd4095, 12'd4000, 12'd4095);
        send_sample(12'd3000, 12'd1000, 12'd2000);
        send_sample(12'd3100, 12'd1100, 12'd2100);
        send_sample(12'd3200, 12'd1200, 12'd2200);
        settle();

        // With a zero pressure limit nothing qualifies, so the touch ends.
        write_reg(REG_PRESSURE_LIMIT, 32'd0);
        for (int i = 0; i < 2 * BURST_LEN; i++)
        begin
            send_sample(12'd2000, 12'd2000, 12'd2000);
        end
        settle();

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph / 3)
                0:
                begin
                    tx_idle_pct = 18;
                    rx_idle_pct = 60;
                end
                1:
                begin
                    tx_idle_pct = 60;
                    rx_idle_pct = 18;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            apply_setting(ph);
            if (ph == 6)
            begin
                hold_req = 1'b1;
            end
            for (int b = 0; b < BURSTS_PER_PHASE; b++)
            begin
                send_burst();
            end
            settle();
        end

        $display("tb_top: %0d sample beats over %0d register settings", sb.samples,
                 settings_used);
        $display("tb_top: events checked: %0d pressed, %0d held, %0d released",
                 sb.kinds_seen[EVT_PRESSED], sb.kinds_seen[EVT_HELD],
                 sb.kinds_seen[EVT_RELEASED]);
        if (sb.error_count == 0)
        begin
            $display("tb_top: done, clean");
        end
        else
        begin
            $display("tb_top: %0d mismatches", sb.error_count);
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
